// ===== design/ecrt_pkg.sv =====
// Shared types, constants and codes of the elevator call request table.
// Depends on nothing; ecrt_dp, ecrt_ctrl and the top level import it.
package ecrt_pkg;

  // Table geometry.
  localparam int FLOORS      = 4;
  localparam int BUTTONS     = 3;
  localparam int STAMP_WIDTH = 16;
  localparam int ENTRIES     = FLOORS * BUTTONS;
  localparam int ENTRY_W     = $clog2(ENTRIES);
  localparam int FLOOR_W     = $clog2(FLOORS);

  // Fixed field widths of the stream words.
  localparam int CMD_W      = 2;
  localparam int FLOOR_NUM_W = 2;
  localparam int BTN_W      = 2;
  localparam int LAMP_W     = 12;
  localparam int AGE_W      = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = {STAMP_WIDTH{1'b1}};

  // Command codes of an input word.
  typedef enum logic [CMD_W-1:0] {
    CMD_PRESS = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Button codes.
  localparam logic [BTN_W-1:0] BTN_UP   = 2'd0;
  localparam logic [BTN_W-1:0] BTN_DOWN = 2'd1;
  localparam logic [BTN_W-1:0] BTN_CAB  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted input word
    logic exec;      // apply the command to the table, restart the scan
    logic scan_rd;   // read the stamp at the scan pointer
    logic query_rd;  // read the stamp of the addressed entry
    logic finish;    // load the output register
  } ecrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // scan pointer is at the last entry
    logic out_hold;   // output register is full and not being taken
  } ecrt_stat_t;

endpackage

// ===== design/ecrt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ecrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ecrt_dp.sv =====
// Datapath of the call request table: active bits, stamp RAM, scan and result word.
// Depends on ecrt_pkg and ecrt_ram.
module ecrt_dp
  import ecrt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  input  ecrt_cmd_t             cmd_i,
  output ecrt_stat_t            stat_o
);

  // Configuration and table state.
  logic                   accept_q;
  logic [ENTRIES-1:0]     active_q, active_d;
  logic [STAMP_WIDTH-1:0] next_q, next_d;

  // Captured input word.
  cmd_e                   cmd_q;
  logic [FLOOR_NUM_W-1:0] floor_q;
  logic [BTN_W-1:0]       btn_q;

  // Scan pointer and the read in flight.
  logic [ENTRY_W-1:0]     scan_idx_q;
  logic [FLOOR_W-1:0]     scan_floor_q;
  logic [BTN_W-1:0]       scan_btn_q;
  logic                   rd_vld_q;
  logic [ENTRY_W-1:0]     rd_idx_q;
  logic [FLOOR_W-1:0]     rd_floor_q;
  logic [BTN_W-1:0]       rd_btn_q;

  // Running oldest requests.
  logic                   cab_found_q, hall_found_q;
  logic [STAMP_WIDTH-1:0] cab_best_q, hall_best_q;
  logic [FLOOR_W-1:0]     cab_floor_q, hall_floor_q;

  // Output register.
  logic                   out_valid_q;
  logic [OUT_DATA_W-1:0]  out_data_q;

  logic                   floor_ok, entry_ok, open_cmd, open_en;
  logic [ENTRY_W-1:0]     ent_idx, rd_addr;
  logic [STAMP_WIDTH-1:0] rdata;
  logic                   ent_active;
  logic [AGE_W-1:0]       ent_age;

  // Addressed entry and its range checks.
  assign floor_ok = 32'(floor_q) < FLOORS;
  assign entry_ok = floor_ok && (32'(btn_q) < BUTTONS);
  assign ent_idx  = ENTRY_W'(32'(floor_q) * BUTTONS + 32'(btn_q));
  assign open_cmd = (cmd_q == CMD_OPEN) || ((cmd_q == CMD_PRESS) && accept_q);
  assign open_en  = cmd_i.exec && open_cmd && entry_ok && !active_q[ent_idx];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_q <= 1'b0;
    end else if (cfg_we_i) begin
      accept_q <= cfg_wdata_i;
    end
  end

  // Input word capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= cmd_e'(in_data_i[CMD_W-1:0]);
      floor_q <= in_data_i[CMD_W+FLOOR_NUM_W-1:CMD_W];
      btn_q   <= in_data_i[CMD_W+FLOOR_NUM_W+BTN_W-1:CMD_W+FLOOR_NUM_W];
    end
  end

  // Command execution on the active bits and the stamp counter.
  always_comb begin
    active_d = active_q;
    next_d   = next_q;
    if (cmd_i.exec) begin
      unique case (cmd_q)
        CMD_PRESS, CMD_OPEN: begin
          if (open_en) begin
            active_d[ent_idx] = 1'b1;
            if (next_q != STAMP_MAX) begin
              next_d = next_q + 1'b1;
            end
          end
        end
        CMD_CLOSE: begin
          for (int f = 0; f < FLOORS; f++) begin
            for (int b = 0; b < BUTTONS; b++) begin
              if (floor_ok && (32'(floor_q) == f)) begin
                active_d[f*BUTTONS+b] = 1'b0;
              end
            end
          end
        end
        CMD_CLEAR: begin
          active_d = '0;
          next_d   = '0;
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      next_q   <= '0;
    end else begin
      active_q <= active_d;
      next_q   <= next_d;
    end
  end

  // Stamp memory: written on open, read by the scan and by the entry query.
  assign rd_addr = cmd_i.scan_rd ? scan_idx_q : ent_idx;

  ecrt_ram #(
    .WIDTH (STAMP_WIDTH),
    .DEPTH (ENTRIES)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (open_en),
    .waddr_i (ent_idx),
    .wdata_i (next_q),
    .re_i    (cmd_i.scan_rd | cmd_i.query_rd),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Scan pointer walks floor by floor, buttons in order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      scan_idx_q   <= '0;
      scan_floor_q <= '0;
      scan_btn_q   <= '0;
    end else if (cmd_i.scan_rd) begin
      scan_idx_q <= scan_idx_q + 1'b1;
      if (scan_btn_q == BTN_CAB) begin
        scan_btn_q   <= BTN_UP;
        scan_floor_q <= scan_floor_q + 1'b1;
      end else begin
        scan_btn_q <= scan_btn_q + 1'b1;
      end
    end
    rd_idx_q   <= scan_idx_q;
    rd_floor_q <= scan_floor_q;
    rd_btn_q   <= scan_btn_q;
  end

  assign stat_o.scan_last = scan_idx_q == ENTRY_W'(ENTRIES - 1);

  // Oldest search; a strictly smaller stamp wins, so earlier entries keep ties.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      cab_found_q  <= 1'b0;
      hall_found_q <= 1'b0;
      cab_floor_q  <= '0;
      hall_floor_q <= '0;
    end else if (rd_vld_q && active_q[rd_idx_q]) begin
      if (rd_btn_q == BTN_CAB) begin
        if (!cab_found_q || (rdata < cab_best_q)) begin
          cab_found_q <= 1'b1;
          cab_best_q  <= rdata;
          cab_floor_q <= rd_floor_q;
        end
      end else begin
        if (!hall_found_q || (rdata < hall_best_q)) begin
          hall_found_q <= 1'b1;
          hall_best_q  <= rdata;
          hall_floor_q <= rd_floor_q;
        end
      end
    end
  end

  // Addressed entry status; the query read has returned by the finish cycle.
  assign ent_active = entry_ok && active_q[ent_idx];
  assign ent_age    = ent_active ? AGE_W'(rdata) : '0;

  // Output register.
  assign stat_o.out_hold = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= {5'b0, ent_age, ent_active, LAMP_W'(active_q),
                     FLOOR_NUM_W'(hall_floor_q), hall_found_q,
                     FLOOR_NUM_W'(cab_floor_q), cab_found_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/ecrt_ctrl.sv =====
// Sequencer of the call request table: execute, scan, query and hand off the result.
// Depends on ecrt_pkg.
module ecrt_ctrl
  import ecrt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ecrt_stat_t stat_i,
  output ecrt_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_QUERY = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_QUERY;
        end
      end
      S_QUERY: begin
        cmd_o.query_rd = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_hold) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/elevator_call_request_table.sv =====
// Top level of the elevator call request table.
// Depends on ecrt_pkg, ecrt_ctrl, ecrt_dp and ecrt_ram.
//
//   Channel  Direction  Word contents
//   s_axis   in         command, floor_number, button_kind
//   m_axis   out        oldest cab and hall floors, lamp mask, addressed entry
//   cfg      in         accept_calls, written on cfg_we_i
//
// A word is accepted only in the idle cycle; the sequencer then applies the command,
// scans the stamp RAM entry by entry through its single read port, reads the addressed
// entry and loads the result into the output register, so a new word is taken only
// after the last result is loaded. While a result waits on m_axis the next word
// is worked on, and the sequencer stalls in its last step until the output is free.
// Reset clears the request table, the stamp counter and accept_calls.
module elevator_call_request_table
  import ecrt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,   // accept_calls
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] command, [3:2] floor_number, [5:4] button_kind, [7:6] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] cab_found, [2:1] oldest_cab_floor, [3] hall_found, [5:4] oldest_hall_floor,
  // [17:6] lamp_mask, [18] entry_active, [34:19] entry_age, [39:35] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  ecrt_cmd_t  cmd;
  ecrt_stat_t stat;

  // Sequencer.
  ecrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table, scan and result word.
  ecrt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
